// ----- hw/rtl/gbcs_pkg.sv -----
// Package for the gated batch class scheduler.
// Holds the field widths, function and status codes and the register reset value.
// No dependencies.
`timescale 1ns / 1ps

package gbcs_pkg;

  localparam int unsigned CLASS_W = 3;
  localparam int unsigned TAG_W   = 8;
  localparam int unsigned TIME_W  = 8;
  localparam int unsigned LIMIT_W = 5;
  localparam int unsigned ENTRY_W = TAG_W + TIME_W;

  localparam logic FUNC_ARRIVE = 1'b0;
  localparam logic FUNC_DONE   = 1'b1;

  localparam logic STATUS_GRANT = 1'b0;
  localparam logic STATUS_DROP  = 1'b1;

  localparam logic [LIMIT_W-1:0] BATCH_LIMIT_RESET = 5'd10;

endpackage

// ----- hw/rtl/gated_batch_class_scheduler.sv -----
// Gated batch class scheduler, top level.
// Uses gbcs_pkg for widths, codes and the register reset value.
`timescale 1ns / 1ps

// One beat in, zero or more beats out. Requests are kept per class in one
// synchronous store (NUM_CLASSES*QUEUE_DEPTH entries of tag:time, registered
// read); per-class head/active/pending counts and the class order ring sit in
// flops. The block works on one input beat at a time: in_ready is high only
// while idle. An arrival is latched, then decoded and applied; if a batch
// starts, the front class is popped from the ring and each grant takes a store
// read, then an output load. A batch-done beat with the gate closed first
// walks all classes, one class per cycle, before any batch starts. A drop
// waits for room in the output register. Grants leave through a single
// output register; a stalled out_ready stalls the grant loop in place. The
// input side accepts a new beat while the last result still waits in it.
module gated_batch_class_scheduler #(
  parameter int unsigned NUM_CLASSES = 8,
  parameter int unsigned QUEUE_DEPTH = 16,
  parameter int unsigned BATCH_MAX   = 16
) (
  input  logic                          clk,
  input  logic                          rst_n,
  // input beats
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic                          in_func,
  input  logic [gbcs_pkg::CLASS_W-1:0]  in_class_id,
  input  logic [gbcs_pkg::TAG_W-1:0]    in_request_tag,
  input  logic [gbcs_pkg::TIME_W-1:0]   in_hold_time,
  // result beats
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic                          out_status,
  output logic [gbcs_pkg::CLASS_W-1:0]  out_grant_class,
  output logic [gbcs_pkg::TAG_W-1:0]    out_grant_tag,
  output logic [gbcs_pkg::TIME_W-1:0]   out_grant_time,
  output logic                          out_last_in_batch,
  // batch_limit register
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [gbcs_pkg::LIMIT_W-1:0]  cfg_batch_limit
);

  localparam int unsigned CW    = (NUM_CLASSES > 1) ? $clog2(NUM_CLASSES) : 1;
  localparam int unsigned QW    = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int unsigned CNW   = $clog2(QUEUE_DEPTH + 1);
  localparam int unsigned OCW   = $clog2(NUM_CLASSES + 1);
  localparam int unsigned LW    = $clog2(BATCH_MAX + 1);
  localparam int unsigned DEPTH = NUM_CLASSES * QUEUE_DEPTH;
  localparam int unsigned AW    = $clog2(DEPTH);

  typedef enum logic [2:0] {
    S_IDLE,   // waiting for an input beat
    S_PROC,   // decode and apply the latched beat
    S_SCAN,   // promote pending requests, one class per cycle
    S_START,  // pop the front class of the ring
    S_GRANT,  // issue the store read for the next grant
    S_RDAT    // store data ready, load the output register
  } state_t;

  state_t state_r, state_nxt;

  // latched input beat
  logic                         func_r;
  logic [gbcs_pkg::CLASS_W-1:0] cls_r;
  logic [gbcs_pkg::TAG_W-1:0]   tag_r;
  logic [gbcs_pkg::TIME_W-1:0]  time_r;

  // control state
  logic                         gate_r, gate_nxt;
  logic [CW-1:0]                bcls_r, bcls_nxt;    // class of current batch
  logic [LW-1:0]                lim_r, lim_nxt;
  logic [LW-1:0]                n_r, n_nxt;          // grants so far
  logic [CW-1:0]                scan_r, scan_nxt;
  logic [CW-1:0]                oh_r, oh_nxt;        // ring head
  logic [OCW-1:0]               oc_r, oc_nxt;        // ring count
  logic [gbcs_pkg::LIMIT_W-1:0] blim_r;

  // output register
  logic                         ov_r, ov_nxt;
  logic                         ost_r, ost_nxt;
  logic [gbcs_pkg::CLASS_W-1:0] ocls_r, ocls_nxt;
  logic [gbcs_pkg::TAG_W-1:0]   otag_r, otag_nxt;
  logic [gbcs_pkg::TIME_W-1:0]  otime_r, otime_nxt;
  logic                         olast_r, olast_nxt;

  // per-class counts
  logic [QW-1:0]  head_r [NUM_CLASSES];
  logic [CNW-1:0] act_r  [NUM_CLASSES];
  logic [CNW-1:0] pend_r [NUM_CLASSES];
  logic [CW-1:0]  ring_r [NUM_CLASSES];

  // request store
  logic [gbcs_pkg::ENTRY_W-1:0] store [DEPTH];
  logic [gbcs_pkg::ENTRY_W-1:0] mem_q_r;

  logic [CW-1:0]  sel_idx;
  logic [QW-1:0]  cur_head, head_nxt;
  logic [CNW-1:0] cur_act, act_nxt, cur_pend, pend_nxt;
  logic           cnt_we;
  logic           push_en;
  logic [CW-1:0]  push_cls;
  logic [CW:0]    tail_sum;
  logic [CW-1:0]  tail_idx;
  logic           mem_we, mem_re;
  logic [AW-1:0]  mem_addr;
  logic [QW-1:0]  slot;
  logic [QW:0]    slot_sum;
  logic [CNW:0]   fill;
  logic           cls_ok, full, out_free, is_last;
  logic [QW-1:0]  head_inc;
  logic [LW:0]    n_inc;
  logic [LW-1:0]  lim_calc;

  assign in_ready          = (state_r == S_IDLE);
  assign cfg_ready         = 1'b1;
  assign out_valid         = ov_r;
  assign out_status        = ost_r;
  assign out_grant_class   = ocls_r;
  assign out_grant_tag     = otag_r;
  assign out_grant_time    = otime_r;
  assign out_last_in_batch = olast_r;

  assign out_free = !ov_r || out_ready;

  // one class index per cycle into the count arrays
  always_comb begin
    case (state_r)
      S_PROC:  sel_idx = CW'(cls_r);
      S_SCAN:  sel_idx = scan_r;
      default: sel_idx = bcls_r;
    endcase
  end

  assign cur_head = head_r[sel_idx];
  assign cur_act  = act_r[sel_idx];
  assign cur_pend = pend_r[sel_idx];

  assign cls_ok   = (7'(cls_r) < 7'(NUM_CLASSES));
  assign fill     = (CNW+1)'(cur_act) + (CNW+1)'(cur_pend);
  assign full     = (fill >= (CNW+1)'(QUEUE_DEPTH));

  // tail slot of the class queue: below twice the depth, one subtract wraps it
  assign slot_sum = (QW+1)'(cur_head) + (QW+1)'(cur_act) + (QW+1)'(cur_pend);
  assign slot     = (slot_sum >= (QW+1)'(QUEUE_DEPTH)) ?
                    QW'(slot_sum - (QW+1)'(QUEUE_DEPTH)) : QW'(slot_sum);

  assign head_inc = (32'(cur_head) + 32'd1 >= QUEUE_DEPTH) ? '0 : QW'(cur_head + 1'b1);

  assign tail_sum = (CW+1)'(oh_r) + (CW+1)'(oc_r);
  assign tail_idx = (tail_sum >= (CW+1)'(NUM_CLASSES)) ?
                    CW'(tail_sum - (CW+1)'(NUM_CLASSES)) : CW'(tail_sum);

  // limit 0 acts as 1, above BATCH_MAX as BATCH_MAX
  always_comb begin
    if (blim_r == '0) begin
      lim_calc = LW'(1);
    end else if (7'(blim_r) > 7'(BATCH_MAX)) begin
      lim_calc = LW'(BATCH_MAX);
    end else begin
      lim_calc = LW'(blim_r);
    end
  end

  assign n_inc   = (LW+1)'(n_r) + (LW+1)'(1);
  assign is_last = (n_inc == (LW+1)'(lim_r)) || (cur_act == CNW'(1));

  always_comb begin
    state_nxt = state_r;
    gate_nxt  = gate_r;
    bcls_nxt  = bcls_r;
    lim_nxt   = lim_r;
    n_nxt     = n_r;
    scan_nxt  = scan_r;
    oh_nxt    = oh_r;
    oc_nxt    = oc_r;
    ov_nxt    = ov_r && !out_ready;
    ost_nxt   = ost_r;
    ocls_nxt  = ocls_r;
    otag_nxt  = otag_r;
    otime_nxt = otime_r;
    olast_nxt = olast_r;
    head_nxt  = cur_head;
    act_nxt   = cur_act;
    pend_nxt  = cur_pend;
    cnt_we    = 1'b0;
    push_en   = 1'b0;
    push_cls  = sel_idx;
    mem_we    = 1'b0;
    mem_re    = 1'b0;
    mem_addr  = AW'(sel_idx) * AW'(QUEUE_DEPTH) + AW'(cur_head);

    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          state_nxt = S_PROC;
        end
      end

      S_PROC: begin
        if (func_r == gbcs_pkg::FUNC_DONE) begin
          scan_nxt  = '0;
          state_nxt = gate_r ? S_SCAN : S_START;
        end else if (!cls_ok) begin
          state_nxt = S_IDLE;
        end else if (full) begin
          // drop beat: wait for room in the output register
          if (out_free) begin
            ov_nxt    = 1'b1;
            ost_nxt   = gbcs_pkg::STATUS_DROP;
            ocls_nxt  = cls_r;
            otag_nxt  = tag_r;
            otime_nxt = '0;
            olast_nxt = 1'b1;
            state_nxt = S_IDLE;
          end
        end else begin
          mem_we   = 1'b1;
          mem_addr = AW'(sel_idx) * AW'(QUEUE_DEPTH) + AW'(slot);
          cnt_we   = 1'b1;
          if (gate_r) begin
            pend_nxt  = cur_pend + 1'b1;
            state_nxt = S_IDLE;
          end else begin
            push_en   = (cur_act == '0);
            act_nxt   = cur_act + 1'b1;
            state_nxt = S_START;
          end
        end
      end

      S_SCAN: begin
        if (cur_pend != '0) begin
          push_en  = (cur_act == '0);
          act_nxt  = CNW'(fill);
          pend_nxt = '0;
          cnt_we   = 1'b1;
        end
        if (32'(scan_r) == NUM_CLASSES - 1) begin
          gate_nxt  = 1'b0;
          state_nxt = S_START;
        end else begin
          scan_nxt = scan_r + 1'b1;
        end
      end

      S_START: begin
        if (gate_r || oc_r == '0) begin
          state_nxt = S_IDLE;
        end else begin
          bcls_nxt  = ring_r[oh_r];
          oh_nxt    = (32'(oh_r) + 32'd1 >= NUM_CLASSES) ? '0 : CW'(oh_r + 1'b1);
          oc_nxt    = oc_r - 1'b1;
          lim_nxt   = lim_calc;
          n_nxt     = '0;
          state_nxt = S_GRANT;
        end
      end

      S_GRANT: begin
        if (cur_act != '0) begin
          mem_re    = 1'b1;
          state_nxt = S_RDAT;
        end else begin
          state_nxt = S_IDLE;
        end
      end

      S_RDAT: begin
        if (out_free) begin
          ov_nxt    = 1'b1;
          ost_nxt   = gbcs_pkg::STATUS_GRANT;
          ocls_nxt  = gbcs_pkg::CLASS_W'(bcls_r);
          otag_nxt  = mem_q_r[gbcs_pkg::ENTRY_W-1:gbcs_pkg::TIME_W];
          otime_nxt = mem_q_r[gbcs_pkg::TIME_W-1:0];
          olast_nxt = is_last;
          head_nxt  = head_inc;
          act_nxt   = cur_act - 1'b1;
          cnt_we    = 1'b1;
          n_nxt     = LW'(n_inc);
          if (is_last) begin
            gate_nxt  = 1'b1;
            // class with requests left goes back to the ring tail
            push_en   = (cur_act != CNW'(1));
            state_nxt = S_IDLE;
          end else begin
            state_nxt = S_GRANT;
          end
        end
      end

      default: state_nxt = S_IDLE;
    endcase

    if (push_en && oc_r < OCW'(NUM_CLASSES)) begin
      oc_nxt = oc_r + 1'b1;
    end else begin
      push_en = 1'b0;
    end
  end

  // state and registered outputs
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      gate_r  <= 1'b0;
      oh_r    <= '0;
      oc_r    <= '0;
      ov_r    <= 1'b0;
      blim_r  <= gbcs_pkg::BATCH_LIMIT_RESET;
    end else begin
      state_r <= state_nxt;
      gate_r  <= gate_nxt;
      oh_r    <= oh_nxt;
      oc_r    <= oc_nxt;
      ov_r    <= ov_nxt;
      if (cfg_valid) begin
        blim_r <= cfg_batch_limit;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (state_r == S_IDLE && in_valid) begin
      func_r <= in_func;
      cls_r  <= in_class_id;
      tag_r  <= in_request_tag;
      time_r <= in_hold_time;
    end
    bcls_r  <= bcls_nxt;
    lim_r   <= lim_nxt;
    n_r     <= n_nxt;
    scan_r  <= scan_nxt;
    ost_r   <= ost_nxt;
    ocls_r  <= ocls_nxt;
    otag_r  <= otag_nxt;
    otime_r <= otime_nxt;
    olast_r <= olast_nxt;
  end

  // per-class counts, one entry written per cycle
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NUM_CLASSES; i++) begin
        head_r[i] <= '0;
        act_r[i]  <= '0;
        pend_r[i] <= '0;
      end
    end else if (cnt_we) begin
      head_r[sel_idx] <= head_nxt;
      act_r[sel_idx]  <= act_nxt;
      pend_r[sel_idx] <= pend_nxt;
    end
  end

  // class order ring, no reset
  always_ff @(posedge clk) begin
    if (push_en) begin
      ring_r[tail_idx] <= push_cls;
    end
  end

  // request store, registered read
  always_ff @(posedge clk) begin
    if (mem_we) begin
      store[mem_addr] <= {tag_r, time_r};
    end
    if (mem_re) begin
      mem_q_r <= store[mem_addr];
    end
  end

endmodule

// ----- tb/gated_batch_class_scheduler_test.sv -----
// Self-checking testbench for the gated batch class scheduler.
// Drives arrival and batch-done beats, predicts every grant and drop in a
// behavioral scheduler model, and checks results in order. Depends on gbcs_pkg.
`timescale 1ns / 1ps

module gated_batch_class_scheduler_test;

  localparam int NCLS  = 8;
  localparam int DEPTH = 16;
  localparam int BMAX  = 16;
  localparam int LIMIT_CYCLES = 400000;

  typedef struct packed {
    logic                         func;
    logic [gbcs_pkg::CLASS_W-1:0] cls;
    logic [gbcs_pkg::TAG_W-1:0]   tag;
    logic [gbcs_pkg::TIME_W-1:0]  tm;
  } req_beat_t;

  typedef struct packed {
    logic                         status;
    logic [gbcs_pkg::CLASS_W-1:0] cls;
    logic [gbcs_pkg::TAG_W-1:0]   tag;
    logic [gbcs_pkg::TIME_W-1:0]  tm;
    logic                         last;
  } grant_beat_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0, in_ready;
  logic in_func = 1'b0;
  logic [gbcs_pkg::CLASS_W-1:0] in_class_id = '0;
  logic [gbcs_pkg::TAG_W-1:0] in_request_tag = '0;
  logic [gbcs_pkg::TIME_W-1:0] in_hold_time = '0;
  logic out_valid, out_ready = 1'b0;
  logic out_status, out_last_in_batch;
  logic [gbcs_pkg::CLASS_W-1:0] out_grant_class;
  logic [gbcs_pkg::TAG_W-1:0] out_grant_tag;
  logic [gbcs_pkg::TIME_W-1:0] out_grant_time;
  logic cfg_valid = 1'b0, cfg_ready;
  logic [gbcs_pkg::LIMIT_W-1:0] cfg_batch_limit = '0;

  gated_batch_class_scheduler dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_func(in_func),
    .in_class_id(in_class_id), .in_request_tag(in_request_tag),
    .in_hold_time(in_hold_time),
    .out_valid(out_valid), .out_ready(out_ready), .out_status(out_status),
    .out_grant_class(out_grant_class), .out_grant_tag(out_grant_tag),
    .out_grant_time(out_grant_time), .out_last_in_batch(out_last_in_batch),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_batch_limit(cfg_batch_limit)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // Scheduler shadow state. Each class queue is a circular buffer; pending
  // requests sit right behind the active ones.
  // ---------------------------------------------------------------------------
  logic [gbcs_pkg::ENTRY_W-1:0] sh_store [NCLS][DEPTH];
  int unsigned sh_head [NCLS];
  int unsigned sh_active [NCLS];
  int unsigned sh_pend [NCLS];
  logic [gbcs_pkg::CLASS_W-1:0] sh_order [$];   // class ring, arrival order
  bit sh_gate_closed;
  logic [gbcs_pkg::LIMIT_W-1:0] sh_limit;

  grant_beat_t grants_due [$];   // expected result beats, oldest first
  req_beat_t   req_q [$];        // beats waiting for the driver
  int errors = 0;
  int n_grants = 0, n_drops = 0, n_sent = 0;
  bit hold_sender = 1'b0;        // sender pauses while set
  bit long_stall_req = 1'b0;     // asks the receiver for a long hold-off
  int max_grants = 0;

  function automatic void expect_beat(grant_beat_t g);
    grants_due.insert(grants_due.size(), g);
  endfunction

  function automatic void enqueue(req_beat_t b);
    req_q.insert(req_q.size(), b);
  endfunction

  function automatic void queue_class(logic [gbcs_pkg::CLASS_W-1:0] c);
    if (sh_order.size() < NCLS) sh_order.insert(sh_order.size(), c);
  endfunction

  // Opens a batch from the front class if the gate allows it.
  function automatic void run_batch();
    int unsigned lim, c, n;
    grant_beat_t g;
    if (sh_gate_closed || sh_order.size() == 0) return;
    c = sh_order.pop_front();
    lim = sh_limit;
    if (lim < 1) lim = 1;
    if (lim > BMAX) lim = BMAX;
    n = 0;
    while (n < lim && sh_active[c] > 0) begin
      g.status = gbcs_pkg::STATUS_GRANT;
      g.cls = gbcs_pkg::CLASS_W'(c);
      g.tag = sh_store[c][sh_head[c]][gbcs_pkg::ENTRY_W-1:gbcs_pkg::TIME_W];
      g.tm = sh_store[c][sh_head[c]][gbcs_pkg::TIME_W-1:0];
      g.last = 1'b0;
      sh_head[c] = (sh_head[c] + 1) % DEPTH;
      sh_active[c]--;
      expect_beat(g);
      n++;
    end
    if (n > 0) begin
      grants_due[grants_due.size()-1].last = 1'b1;
      sh_gate_closed = 1'b1;
      if (n > max_grants) max_grants = n;
    end
    // leftover members go back to the tail of the ring
    if (sh_active[c] > 0) queue_class(gbcs_pkg::CLASS_W'(c));
  endfunction

  function automatic void predict_schedule(req_beat_t b);
    int unsigned c, slot;
    grant_beat_t g;
    c = b.cls;
    if (b.func == gbcs_pkg::FUNC_ARRIVE) begin
      if (sh_active[c] + sh_pend[c] >= DEPTH) begin
        g.status = gbcs_pkg::STATUS_DROP; g.cls = b.cls; g.tag = b.tag; g.tm = '0;
        g.last = 1'b1;
        expect_beat(g);
        return;
      end
      slot = (sh_head[c] + sh_active[c] + sh_pend[c]) % DEPTH;
      sh_store[c][slot] = {b.tag, b.tm};
      if (sh_gate_closed) sh_pend[c]++;
      else begin
        if (sh_active[c] == 0) queue_class(b.cls);
        sh_active[c]++;
      end
    end else if (sh_gate_closed) begin
      // promote pending requests in ascending class order
      for (int k = 0; k < NCLS; k++) begin
        if (sh_pend[k] > 0) begin
          if (sh_active[k] == 0) queue_class(gbcs_pkg::CLASS_W'(k));
          sh_active[k] += sh_pend[k];
          sh_pend[k] = 0;
        end
      end
      sh_gate_closed = 1'b0;
    end
    run_batch();
  endfunction

  // ---------------------------------------------------------------------------
  // Driver: bursts of beats with random gaps; predicts on acceptance.
  // ---------------------------------------------------------------------------
  int gap_left = 0, burst_left = 0;
  req_beat_t cur;
  bit taken = 1'b0;              // current beat accepted, driver may move on

  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && in_ready) begin
        predict_schedule(cur);
        n_sent++;
        taken = 1'b1;
      end
    end
  end

  always @(negedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
      taken = 1'b0;
    end else if (in_valid && !taken) begin
      // hold the beat steady until accepted
    end else begin
      taken = 1'b0;
      if (hold_sender || req_q.size() == 0) begin
        in_valid <= 1'b0;
      end else if (gap_left > 0) begin
        gap_left--;
        in_valid <= 1'b0;
      end else begin
        cur = req_q.pop_front();
        in_valid <= 1'b1;
        in_func <= cur.func;
        in_class_id <= cur.cls;
        in_request_tag <= cur.tag;
        in_hold_time <= cur.tm;
        if (burst_left > 0) burst_left--;
        else begin
          burst_left = $urandom_range(0, 12);
          gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 6);
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Receiver: own stall pattern, plus one long hold-off on request.
  // ---------------------------------------------------------------------------
  int stall_phase = 0, long_count = 0;

  always @(negedge clk) begin
    if (!rst_n) out_ready <= 1'b0;
    else if (long_stall_req && long_count < 300) begin
      long_count++;
      out_ready <= 1'b0;
    end else begin
      stall_phase = (stall_phase + 1) % 40;
      if (stall_phase < 12) out_ready <= 1'b1;        // stall-free stretch
      else out_ready <= ($urandom_range(0, 3) != 0);
    end
  end

  // Monitor: compare each result beat with the oldest expectation.
  always @(posedge clk) begin
    grant_beat_t e;
    if (rst_n && out_valid && out_ready) begin
      if (grants_due.size() == 0) begin
        $error("unexpected result beat class=%0d tag=%0d", out_grant_class, out_grant_tag);
        errors++;
      end else begin
        e = grants_due.pop_front();
        if (out_status !== e.status) begin
          $error("status: expected %0d got %0d", e.status, out_status); errors++;
        end
        if (out_grant_class !== e.cls) begin
          $error("grant_class: expected %0d got %0d", e.cls, out_grant_class); errors++;
        end
        if (out_grant_tag !== e.tag) begin
          $error("grant_tag: expected %0d got %0d", e.tag, out_grant_tag); errors++;
        end
        if (out_grant_time !== e.tm) begin
          $error("grant_time: expected %0d got %0d", e.tm, out_grant_time); errors++;
        end
        if (out_last_in_batch !== e.last) begin
          $error("last_in_batch: expected %0d got %0d", e.last, out_last_in_batch);
          errors++;
        end
        if (e.status == gbcs_pkg::STATUS_DROP) n_drops++;
        else n_grants++;
      end
    end
  end

  // Watchdog on total run length.
  int cycles = 0;
  always @(posedge clk) begin
    cycles++;
    if (cycles > LIMIT_CYCLES) begin
      $display("timeout after %0d cycles", cycles);
      $display("*** FAILED ***");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------
  function automatic req_beat_t mk_arrive(int c, int t, int h);
    req_beat_t b;
    b.func = gbcs_pkg::FUNC_ARRIVE;
    b.cls = gbcs_pkg::CLASS_W'(c);
    b.tag = gbcs_pkg::TAG_W'(t);
    b.tm = gbcs_pkg::TIME_W'(h);
    return b;
  endfunction

  function automatic req_beat_t mk_done();
    req_beat_t b;
    b.func = gbcs_pkg::FUNC_DONE;
    // ignored payload
    b.cls = gbcs_pkg::CLASS_W'($urandom);
    b.tag = gbcs_pkg::TAG_W'($urandom);
    b.tm = gbcs_pkg::TIME_W'($urandom);
    return b;
  endfunction

  // Wait until the driver has drained its queue and every result has arrived,
  // then let the block settle (a done with nothing waiting leaves no result).
  task automatic drain();
    while (req_q.size() > 0 || in_valid || grants_due.size() > 0) @(posedge clk);
    repeat (NCLS + 8) @(posedge clk);
  endtask

  task automatic write_limit(logic [gbcs_pkg::LIMIT_W-1:0] v);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_batch_limit <= v;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    sh_limit = v;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // Well-formed phase: arrivals for a random number of the lowest classes, mixed with done beats.
  task automatic random_phase(int n_items);
    int hot;
    hot = $urandom_range(1, NCLS);
    for (int i = 0; i < n_items; i++) begin
      if ($urandom_range(0, 99) < 30) enqueue(mk_done());
      else enqueue(mk_arrive($urandom_range(0, hot - 1), $urandom, $urandom));
    end
  endtask

  initial begin
    sh_limit = gbcs_pkg::BATCH_LIMIT_RESET;
    sh_gate_closed = 1'b0;
    foreach (sh_head[k]) begin
      sh_head[k] = 0; sh_active[k] = 0; sh_pend[k] = 0;
    end
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Directed: field extremes, done while the gate is open with nothing
    // waiting, and a queue overflow.
    enqueue(mk_done());
    enqueue(mk_arrive(0, 8'h00, 8'h00));
    enqueue(mk_arrive(7, 8'hFF, 8'hFF));
    enqueue(mk_arrive(7, 8'hA5, 8'h5A));
    enqueue(mk_done());
    enqueue(mk_done());
    enqueue(mk_done());
    for (int i = 0; i < 18; i++) enqueue(mk_arrive(3, i, 255 - i));
    drain();

    // Batch limit 1: a run of done beats, then one arrival for each class.
    write_limit(5'd1);
    enqueue(mk_done());
    for (int i = 0; i < 6; i++) enqueue(mk_done());
    for (int i = 0; i < 8; i++) enqueue(mk_arrive(i, 8'h80 | i, i));
    drain();

    // Long receiver hold-off while the sender keeps going.
    write_limit(5'd16);
    long_stall_req = 1'b1;
    random_phase(40);
    drain();

    // Random phases through several limits, including out-of-range ones.
    write_limit(5'd0);
    random_phase(30);
    drain();
    write_limit(5'd31);
    random_phase(30);
    drain();
    write_limit(gbcs_pkg::LIMIT_W'($urandom_range(2, 9)));
    random_phase(40);
    // sender pauses with beats still queued until every expected result is in
    while (req_q.size() > 20) @(posedge clk);
    hold_sender = 1'b1;
    while (in_valid || grants_due.size() > 0) @(posedge clk);
    hold_sender = 1'b0;
    random_phase(40);
    for (int i = 0; i < 12; i++) enqueue(mk_done());
    drain();

    $display("sent %0d beats: %0d grants, %0d drops, largest batch %0d",
             n_sent, n_grants, n_drops, max_grants);
    $display("limits 1, 16, 0, 31 and random; long output stall and input pause exercised");
    if (errors == 0) $display("*** PASSED ***");
    else $display("*** FAILED ***");
    $finish;
  end

endmodule
